// ===== sv/pps_pkg.sv =====
// Package for the preemptive priority task scheduler.
// Holds field widths, register map, opcodes, channel payload types and the FSM type.
// No dependencies; the interfaces and the core import it.
package pps_pkg;

  localparam int TASK_IDX_W   = 4;
  localparam int TICK_W       = 24;
  localparam int PRIO_W       = 8;
  localparam int BURST_W      = 16;
  localparam int TOTAL_W      = 18;
  localparam int TASK_COUNT_W = 5;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = 1'd0;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic                  mode;
    logic [TASK_IDX_W-1:0] task_index;
    logic [TICK_W-1:0]     arrival_tick;
    logic [PRIO_W-1:0]     task_priority;
    logic [BURST_W-1:0]    first_burst;
    logic [BURST_W-1:0]    io_burst;
    logic [BURST_W-1:0]    second_burst;
  } pps_in_t;

  typedef struct packed {
    logic                  ran_valid;
    logic [TASK_IDX_W-1:0] ran_task;
    logic                  finished;
    logic [TICK_W-1:0]     finish_tick;
    logic [TICK_W-1:0]     turnaround;
    logic [TICK_W-1:0]     waiting;
    logic [TICK_W-1:0]     response;
    logic [TICK_W-1:0]     now_tick;
    logic [TICK_W-1:0]     busy_ticks;
    logic [TICK_W-1:0]     idle_ticks;
    logic                  all_done;
  } pps_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_UPDATE,
    ST_STATS,
    ST_EMIT
  } pps_state_t;

endpackage

// ===== sv/pps_in_if.sv =====
// Input channel of the scheduler: valid/ready handshake with a task or tick item.
// Depends on pps_pkg for the payload type.
interface pps_in_if import pps_pkg::*; ();
  logic    valid;
  logic    ready;
  pps_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/pps_out_if.sv =====
// Result channel of the scheduler: valid/ready handshake with one result per item.
// Depends on pps_pkg for the payload type.
interface pps_out_if import pps_pkg::*; ();
  logic     valid;
  logic     ready;
  pps_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/pps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]      wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/preemptive_priority_task_scheduler_core.sv =====
// Preemptive priority task scheduler, one tick or one table load per transfer.
// A load transfer passes through LOAD and EMIT; a tick passes through SCAN, UPDATE, STATS and
// EMIT, the scan reading the task RAM one entry per cycle through its read port.
// A tick with every task done goes straight to EMIT. Input is taken again once the result
// sits in the output register; EMIT waits while that register holds a result not yet taken.
// Reset (synchronous, rst_n low) clears time, counters and all per-task flags at once.
module preemptive_priority_task_scheduler_core import pps_pkg::*; #(
  parameter int MAX_TASKS = 16,
  parameter int TIME_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pps_in_if.sink                in_ch,
  pps_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int T  = TIME_BITS;
  localparam int WW = (T > TOTAL_W) ? T : TOTAL_W;
  localparam logic [T-1:0] TIME_MAX = {T{1'b1}};

  // One task entry as held in the RAM. Flags live in flip-flops so that reset
  // clears them at once; first_run and io_end only matter once the flags say so.
  typedef struct packed {
    logic [T-1:0]       arrival;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] b1;
    logic [BURST_W-1:0] io;
    logic [BURST_W-1:0] b2;
    logic [BURST_W-1:0] rem1;
    logic [BURST_W-1:0] rem2;
    logic [T-1:0]       first_run;
    logic [T-1:0]       io_end;
  } entry_t;

  localparam int EW = $bits(entry_t);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  pps_state_t              state_r, state_nxt;
  pps_in_t                 item_r, item_nxt;
  logic [TASK_COUNT_W-1:0] task_count_r, task_count_nxt;
  logic [T-1:0]            cur_r, cur_nxt;
  logic [T-1:0]            busy_r, busy_nxt;
  logic [T-1:0]            idle_r, idle_nxt;
  logic [MAX_TASKS-1:0]    done_r, done_nxt;
  logic [MAX_TASKS-1:0]    in_io_r, in_io_nxt;
  logic [MAX_TASKS-1:0]    ran_r, ran_nxt;

  // scan sequencer
  logic [CW-1:0]           issue_cnt_r, issue_cnt_nxt;
  logic                    proc_vld_r, proc_vld_nxt;
  logic [AW-1:0]           proc_idx_r, proc_idx_nxt;
  logic                    found_r, found_nxt;
  logic [AW-1:0]           best_idx_r, best_idx_nxt;
  logic [PRIO_W-1:0]       best_prio_r, best_prio_nxt;
  entry_t                  sel_r, sel_nxt;

  // result staging
  logic                    rv_r, rv_nxt;
  logic [TASK_IDX_W-1:0]   ran_task_r, ran_task_nxt;
  logic                    fin_r, fin_nxt;
  logic [T-1:0]            fr_r, fr_nxt;
  logic [T-1:0]            tat_r, tat_nxt;
  logic [T-1:0]            resp_r, resp_nxt;
  logic [TOTAL_W-1:0]      tot_r, tot_nxt;
  logic                    out_valid_r, out_valid_nxt;
  pps_out_t                out_data_r, out_data_nxt;

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  logic                 in_ready, in_fire, emit_go;
  logic [CW-1:0]        n_used;
  logic [MAX_TASKS-1:0] used_mask;
  logic                 every_done;
  logic                 issuing, scan_done;
  logic                 cfg_wr;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [EW-1:0]        ram_wdata, ram_rdata;
  entry_t               rd_entry, ld_entry, upd_entry;
  logic                 ld_in_range;
  logic [AW-1:0]        ld_addr;

  logic                 arr_ok, io_over, elig, better;
  logic [T-1:0]         cur_inc, busy_inc, idle_inc;
  logic [T:0]           io_sum;
  logic [T-1:0]         io_end_new, fr_new;
  logic [BURST_W-1:0]   rem1_new, rem2_new;
  logic                 go_io, fin_new;
  logic [WW-1:0]        wait_diff, wait_val;

  pps_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TASKS)
  ) u_task_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Entries in use: zero acts as one, anything past the table acts as the table.
  always_comb begin
    priority if (task_count_r == '0) begin
      n_used = CW'(1);
    end else if (int'(task_count_r) > MAX_TASKS) begin
      n_used = CW'(MAX_TASKS);
    end else begin
      n_used = CW'(task_count_r);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      used_mask[i] = (i < int'(n_used));
    end
  end

  assign every_done = &(done_r | ~used_mask);

  assign in_fire   = in_ch.valid && in_ready;
  assign emit_go   = !out_valid_r || out_ch.ready;
  assign issuing   = (state_r == ST_SCAN) && (issue_cnt_r < n_used);
  assign scan_done = (state_r == ST_SCAN) && !issuing && !proc_vld_r;
  assign cfg_wr    = psel && penable && pwrite;

  assign pready = 1'b1;
  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_TASK_COUNT) ?
                  CFG_DATA_W'(task_count_r) : '0;

  // Load decode: an index past the table is dropped.
  assign ld_in_range = int'(item_r.task_index) < MAX_TASKS;
  assign ld_addr     = AW'(item_r.task_index);

  always_comb begin
    ld_entry           = '0;
    ld_entry.arrival   = T'(item_r.arrival_tick);
    ld_entry.prio      = item_r.task_priority;
    ld_entry.b1        = item_r.first_burst;
    ld_entry.io        = item_r.io_burst;
    ld_entry.b2        = item_r.second_burst;
    ld_entry.rem1      = item_r.first_burst;
    ld_entry.rem2      = item_r.second_burst;
  end

  // Scan compare unit: one entry per cycle from the RAM read port. I/O that has
  // ended counts as rejoined before eligibility is judged.
  assign rd_entry = entry_t'(ram_rdata);
  assign arr_ok   = rd_entry.arrival <= cur_r;
  assign io_over  = rd_entry.io_end <= cur_r;
  assign elig     = arr_ok && !done_r[proc_idx_r] && (!in_io_r[proc_idx_r] || io_over);
  assign better   = elig && (!found_r || (rd_entry.prio < best_prio_r));

  // Run-tick update of the chosen entry.
  assign cur_inc  = (cur_r == TIME_MAX)  ? cur_r  : cur_r + T'(1);
  assign busy_inc = (busy_r == TIME_MAX) ? busy_r : busy_r + T'(1);
  assign idle_inc = (idle_r == TIME_MAX) ? idle_r : idle_r + T'(1);

  assign fr_new   = ran_r[best_idx_r] ? sel_r.first_run : cur_r;
  // spend the first burst, then the second
  assign rem1_new = (sel_r.rem1 != '0) ? sel_r.rem1 - BURST_W'(1) : sel_r.rem1;
  assign rem2_new = ((sel_r.rem1 == '0) && (sel_r.rem2 != '0)) ?
                    sel_r.rem2 - BURST_W'(1) : sel_r.rem2;
  assign go_io    = (rem1_new == '0) && (rem2_new == sel_r.b2) &&
                    (sel_r.io != '0) && (sel_r.b1 != '0);
  assign fin_new  = !go_io && (rem1_new == '0) && (rem2_new == '0);

  // I/O ends at (now + 1) + io, saturated
  assign io_sum     = {1'b0, cur_r} + (T + 1)'(sel_r.io) + (T + 1)'(1);
  assign io_end_new = io_sum[T] ? TIME_MAX : io_sum[T-1:0];

  always_comb begin
    upd_entry           = sel_r;
    upd_entry.rem1      = rem1_new;
    upd_entry.rem2      = rem2_new;
    upd_entry.first_run = fr_new;
    if (go_io) begin
      upd_entry.io_end = io_end_new;
    end
  end

  // Waiting time, clamped at zero
  assign wait_diff = WW'(tat_r) - WW'(tot_r);
  assign wait_val  = (WW'(tat_r) > WW'(tot_r)) ? wait_diff : '0;

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          priority if (in_ch.data.mode == MODE_LOAD) begin
            state_nxt = ST_LOAD;
          end else if (every_done) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_LOAD:   state_nxt = ST_EMIT;
      ST_SCAN: begin
        if (scan_done) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: state_nxt = ST_STATS;
      ST_STATS:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // FSM outputs: handshakes and RAM port
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = best_idx_r;
    ram_wdata = upd_entry;
    ram_raddr = AW'(issue_cnt_r);
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_LOAD: begin
        ram_we    = ld_in_range;
        ram_waddr = ld_addr;
        ram_wdata = ld_entry;
      end
      ST_UPDATE: ram_we = found_r;
      ST_SCAN, ST_STATS, ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Datapath next values
  // ---------------------------------------------------------------------------
  always_comb begin
    item_nxt       = item_r;
    task_count_nxt = task_count_r;
    cur_nxt        = cur_r;
    busy_nxt       = busy_r;
    idle_nxt       = idle_r;
    done_nxt       = done_r;
    in_io_nxt      = in_io_r;
    ran_nxt        = ran_r;
    issue_cnt_nxt  = issue_cnt_r;
    proc_vld_nxt   = 1'b0;
    proc_idx_nxt   = proc_idx_r;
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_prio_nxt  = best_prio_r;
    sel_nxt        = sel_r;
    rv_nxt         = rv_r;
    ran_task_nxt   = ran_task_r;
    fin_nxt        = fin_r;
    fr_nxt         = fr_r;
    tat_nxt        = tat_r;
    resp_nxt       = resp_r;
    tot_nxt        = tot_r;
    out_data_nxt   = out_data_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    if (cfg_wr && (paddr[CFG_ADDR_W-1:2] == REG_TASK_COUNT)) begin
      task_count_nxt = pwdata[TASK_COUNT_W-1:0];
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          item_nxt      = in_ch.data;
          issue_cnt_nxt = '0;
          found_nxt     = 1'b0;
          rv_nxt        = 1'b0;
          ran_task_nxt  = '0;
          fin_nxt       = 1'b0;
        end
      end

      ST_LOAD: begin
        // reload restarts the entry
        if (ld_in_range) begin
          done_nxt[ld_addr]  = 1'b0;
          in_io_nxt[ld_addr] = 1'b0;
          ran_nxt[ld_addr]   = 1'b0;
        end
      end

      ST_SCAN: begin
        if (issuing) begin
          issue_cnt_nxt = issue_cnt_r + CW'(1);
          proc_vld_nxt  = 1'b1;
          proc_idx_nxt  = AW'(issue_cnt_r);
        end
        if (proc_vld_r) begin
          if (in_io_r[proc_idx_r] && io_over) begin
            in_io_nxt[proc_idx_r] = 1'b0;
          end
          // strict compare keeps the lowest index on a tie
          if (better) begin
            found_nxt     = 1'b1;
            best_idx_nxt  = proc_idx_r;
            best_prio_nxt = rd_entry.prio;
            sel_nxt       = rd_entry;
          end
        end
      end

      ST_UPDATE: begin
        cur_nxt = cur_inc;
        if (found_r) begin
          ran_nxt[best_idx_r] = 1'b1;
          if (go_io) begin
            in_io_nxt[best_idx_r] = 1'b1;
          end
          if (fin_new) begin
            done_nxt[best_idx_r] = 1'b1;
          end
          busy_nxt     = busy_inc;
          rv_nxt       = 1'b1;
          ran_task_nxt = TASK_IDX_W'(best_idx_r);
          fin_nxt      = fin_new;
          fr_nxt       = fr_new;
        end else begin
          idle_nxt = idle_inc;
        end
      end

      ST_STATS: begin
        tat_nxt  = cur_r - sel_r.arrival;
        resp_nxt = fr_r - sel_r.arrival;
        tot_nxt  = TOTAL_W'(sel_r.b1) + TOTAL_W'(sel_r.b2) + TOTAL_W'(sel_r.io);
      end

      ST_EMIT: begin
        if (emit_go) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.ran_valid   = rv_r;
          out_data_nxt.ran_task    = ran_task_r;
          out_data_nxt.finished    = fin_r;
          out_data_nxt.finish_tick = fin_r ? TICK_W'(cur_r)    : '0;
          out_data_nxt.turnaround  = fin_r ? TICK_W'(tat_r)    : '0;
          out_data_nxt.waiting     = fin_r ? TICK_W'(wait_val) : '0;
          out_data_nxt.response    = fin_r ? TICK_W'(resp_r)   : '0;
          out_data_nxt.now_tick    = TICK_W'(cur_r);
          out_data_nxt.busy_ticks  = TICK_W'(busy_r);
          out_data_nxt.idle_ticks  = TICK_W'(idle_r);
          out_data_nxt.all_done    = every_done;
        end
      end

      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      task_count_r <= TASK_COUNT_W'(1);
      cur_r        <= '0;
      busy_r       <= '0;
      idle_r       <= '0;
      done_r       <= '0;
      in_io_r      <= '0;
      ran_r        <= '0;
      issue_cnt_r  <= '0;
      proc_vld_r   <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      task_count_r <= task_count_nxt;
      cur_r        <= cur_nxt;
      busy_r       <= busy_nxt;
      idle_r       <= idle_nxt;
      done_r       <= done_nxt;
      in_io_r      <= in_io_nxt;
      ran_r        <= ran_nxt;
      issue_cnt_r  <= issue_cnt_nxt;
      proc_vld_r   <= proc_vld_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    proc_idx_r  <= proc_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_prio_r <= best_prio_nxt;
    sel_r       <= sel_nxt;
    rv_r        <= rv_nxt;
    ran_task_r  <= ran_task_nxt;
    fin_r       <= fin_nxt;
    fr_r        <= fr_nxt;
    tat_r       <= tat_nxt;
    resp_r      <= resp_nxt;
    tot_r       <= tot_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule
